// ----- sv/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants, controller states and the command and status structs that
// join the merge sort controller to its datapath.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    // Address of one stored element.
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    // Counters that must also hold MAX_ITEMS itself.
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    // Sums of a segment base and a run length.
    localparam int SUM_W     = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_INIT,
        ST_SEG_SETUP,
        ST_MERGE_READ,
        ST_MERGE_WRITE,
        ST_EMIT_INIT,
        ST_EMIT_READ,
        ST_EMIT_OUT
    } mse_state_t;

    typedef struct packed {
        logic load;       // Store the incoming request's value.
        logic sort_init;  // Start the first pass with run width one.
        logic seg_setup;  // Set up bounds and pointers of one merge segment.
        logic mrg_write;  // Write the smaller head element to the target.
        logic seg_next;   // Advance to the next segment of this pass.
        logic pass_next;  // Double the run width and swap the two memories.
        logic emit_init;  // Rewind the read pointer for the output phase.
        logic emit_step;  // Advance the read pointer after one result.
        logic finish;     // Clear the count and the drop flag.
    } mse_cmd_t;

    typedef struct packed {
        logic multi;      // More than one element is stored.
        logic seg_done;   // This write fills the last slot of the segment.
        logic pass_done;  // No further segment in this pass.
        logic sort_done;  // The pass just finished is the final one.
        logic emit_last;  // The element on the outputs is the final one.
    } mse_stat_t;

endpackage

// ----- sv/mse_ctrl.sv -----
// ----------------------------------------------------------------------------
// mse_ctrl
// Controller state machine: sequences load, merge passes and output phase.
// ----------------------------------------------------------------------------
module mse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              is_last,
    input  mse_pkg::mse_stat_t stat,
    output mse_pkg::mse_cmd_t  cmd,
    output logic              busy,
    output logic              result_strobe
);
    import mse_pkg::*;

    mse_state_t state_reg;
    mse_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        busy          = 1'b1;
        result_strobe = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_SORT_INIT;
                    end
                end
            end
            ST_SORT_INIT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = stat.multi ? ST_SEG_SETUP : ST_EMIT_INIT;
            end
            ST_SEG_SETUP:
            begin
                cmd.seg_setup = 1'b1;
                state_next    = ST_MERGE_READ;
            end
            ST_MERGE_READ:
            begin
                state_next = ST_MERGE_WRITE;
            end
            ST_MERGE_WRITE:
            begin
                cmd.mrg_write = 1'b1;
                if (!stat.seg_done)
                begin
                    state_next = ST_MERGE_READ;
                end
                else if (!stat.pass_done)
                begin
                    cmd.seg_next = 1'b1;
                    state_next   = ST_SEG_SETUP;
                end
                else
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = stat.sort_done ? ST_EMIT_INIT : ST_SEG_SETUP;
                end
            end
            ST_EMIT_INIT:
            begin
                cmd.emit_init = 1'b1;
                state_next    = ST_EMIT_READ;
            end
            ST_EMIT_READ:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                result_strobe = 1'b1;
                cmd.emit_step = 1'b1;
                if (stat.emit_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/mse_datapath.sv -----
// ----------------------------------------------------------------------------
// mse_datapath
// Element store, merge buffer, run pointers and the comparator of the merge.
// ----------------------------------------------------------------------------
module mse_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  mse_pkg::mse_cmd_t                  cmd,
    input  logic signed [mse_pkg::DATA_W-1:0]  item_value,
    output mse_pkg::mse_stat_t                 stat,
    output logic signed [mse_pkg::DATA_W-1:0]  sorted_value,
    output logic                               run_end,
    output logic                               dropped_items
);
    import mse_pkg::*;

    logic signed [DATA_W-1:0] store_mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] buf_mem   [MAX_ITEMS];

    logic signed [DATA_W-1:0] store_a_reg;
    logic signed [DATA_W-1:0] store_b_reg;
    logic signed [DATA_W-1:0] buf_a_reg;
    logic signed [DATA_W-1:0] buf_b_reg;

    logic [CNT_W-1:0] count_reg;
    logic             overflow_reg;
    logic             src_buf_reg;   // The merge buffer holds the current runs.
    logic [CNT_W-1:0] width_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] mid_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;

    logic signed [DATA_W-1:0] head_a;
    logic signed [DATA_W-1:0] head_b;
    logic signed [DATA_W-1:0] wr_data;
    logic                     take_left;
    logic                     store_full;
    logic [SUM_W-1:0]         lo_plus_w;
    logic [SUM_W-1:0]         lo_plus_2w;
    logic [SUM_W-1:0]         two_w;
    logic [SUM_W-1:0]         n_ext;
    logic [CNT_W-1:0]         mid_val;
    logic [CNT_W-1:0]         hi_val;

    assign head_a     = src_buf_reg ? buf_a_reg : store_a_reg;
    assign head_b     = src_buf_reg ? buf_b_reg : store_b_reg;
    // Ties go to the left run, which keeps the sort stable.
    assign take_left  = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (head_a <= head_b));
    assign wr_data    = take_left ? head_a : head_b;
    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));

    assign n_ext      = SUM_W'(count_reg);
    assign two_w      = {width_reg, 1'b0};
    assign lo_plus_w  = SUM_W'(lo_reg) + SUM_W'(width_reg);
    assign lo_plus_2w = SUM_W'(lo_reg) + two_w;
    assign mid_val    = (lo_plus_w  > n_ext) ? count_reg : lo_plus_w[CNT_W-1:0];
    assign hi_val     = (lo_plus_2w > n_ext) ? count_reg : lo_plus_2w[CNT_W-1:0];

    assign stat.multi     = (count_reg > CNT_W'(1));
    assign stat.seg_done  = ((k_reg + CNT_W'(1)) == hi_reg);
    assign stat.pass_done = (lo_plus_2w >= n_ext);
    assign stat.sort_done = (two_w >= n_ext);
    assign stat.emit_last = ((i_reg + CNT_W'(1)) == count_reg);

    assign sorted_value  = head_a;
    assign run_end       = stat.emit_last;
    assign dropped_items = overflow_reg;

    // Both memories are read at the two run heads every cycle.
    always_ff @(posedge clk)
    begin
        store_a_reg <= store_mem[i_reg[ADDR_W-1:0]];
        store_b_reg <= store_mem[j_reg[ADDR_W-1:0]];
        buf_a_reg   <= buf_mem[i_reg[ADDR_W-1:0]];
        buf_b_reg   <= buf_mem[j_reg[ADDR_W-1:0]];
        if (cmd.load && !store_full)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= item_value;
        end
        else if (cmd.mrg_write && src_buf_reg)
        begin
            store_mem[k_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.mrg_write && !src_buf_reg)
        begin
            buf_mem[k_reg[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            src_buf_reg  <= 1'b0;
            width_reg    <= '0;
            lo_reg       <= '0;
            mid_reg      <= '0;
            hi_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (store_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.finish)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            if (cmd.sort_init)
            begin
                width_reg   <= CNT_W'(1);
                lo_reg      <= '0;
                src_buf_reg <= 1'b0;
            end
            if (cmd.seg_setup)
            begin
                mid_reg <= mid_val;
                hi_reg  <= hi_val;
                i_reg   <= lo_reg;
                j_reg   <= mid_val;
                k_reg   <= lo_reg;
            end
            if (cmd.mrg_write)
            begin
                k_reg <= k_reg + CNT_W'(1);
                if (take_left)
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + CNT_W'(1);
                end
            end
            if (cmd.seg_next)
            begin
                lo_reg <= lo_plus_2w[CNT_W-1:0];
            end
            if (cmd.pass_next)
            begin
                width_reg   <= two_w[CNT_W-1:0];
                lo_reg      <= '0;
                src_buf_reg <= !src_buf_reg;
            end
            if (cmd.emit_init)
            begin
                i_reg <= '0;
            end
            if (cmd.emit_step)
            begin
                i_reg <= i_reg + CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/merge_sort_engine.sv -----
// Sequence: each accepted request stores one element; after the closing request
// the sort starts, then each pass sets up every segment and reads and writes
// each element in turn, then the output phase reads and presents each result.
// Throughput: one set at a time; a new set is taken only once the last result
// of the previous set has been presented.
// Reset: rst_n clears the element count, the drop flag and the controller.
// Results cannot be stalled: each is valid for exactly one cycle.
// ----------------------------------------------------------------------------
// merge_sort_engine
// Stable bottom-up merge sort of up to MAX_ITEMS signed 32-bit values.
// ----------------------------------------------------------------------------
module merge_sort_engine
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [mse_pkg::DATA_W-1:0]  item_value,
    input  logic                               is_last,
    output logic                               result_strobe,
    output logic signed [mse_pkg::DATA_W-1:0]  sorted_value,
    output logic                               run_end,
    output logic                               dropped_items
);
    import mse_pkg::*;

    // The controller issues one command word per cycle; the datapath answers
    // with status flags computed from its pointers. A request is taken only
    // in the idle state, where busy is low. The request carrying is_last
    // closes the set and launches the sort. Each pass merges pairs of runs
    // from one memory into the other, so no copy-back is needed; the output
    // phase reads from whichever memory the last pass wrote.
    mse_cmd_t  cmd;
    mse_stat_t stat;

    mse_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .is_last       (is_last),
        .stat          (stat),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    // Elements beyond the store capacity are dropped; the drop flag then
    // shows on every result of that set.
    mse_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item_value    (item_value),
        .stat          (stat),
        .sorted_value  (sorted_value),
        .run_end       (run_end),
        .dropped_items (dropped_items)
    );

endmodule

// ----- verif/merge_sort_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine testbench
// Feeds sets of signed values through the start/busy request port. A local
// predictor sorts each set and queues the run it expects. Every result strobe
// is then checked field by field against the oldest queued element.
// ----------------------------------------------------------------------------
module testbench;
    import mse_pkg::*;

    localparam int TOTAL_REQUESTS = 370;
    // From this request on, the sender never idles.
    localparam int QUIET_FROM     = 330;
    // The worst case stays far below this limit.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int DIRECTED_ROWS  = 15;

    typedef logic signed [DATA_W-1:0] elem_t;

    localparam elem_t MOST_NEG = 32'h8000_0000;
    localparam elem_t MOST_POS = 32'h7FFF_FFFF;

    typedef struct packed {
        elem_t value;
        logic  run_end;
        logic  dropped;
    } sorted_elem_t;

    // A pinned row closes a one-element set, so its result is typed in.
    typedef struct packed {
        elem_t value;
        logic  last;
        logic  pinned;
        elem_t pin_value;
    } stim_row_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    logic  busy;
    elem_t item_value;
    logic  is_last;
    logic  result_strobe;
    elem_t sorted_value;
    logic  run_end;
    logic  dropped_items;

    sorted_elem_t sorted_run_q[$];
    elem_t        open_set[$];
    logic         open_set_lost;
    int           error_count = 0;
    int           requests_sent = 0;
    int           cycle_count = 0;
    stim_row_t    directed_rows [0:DIRECTED_ROWS-1];

    merge_sort_engine dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item_value    (item_value),
        .is_last       (is_last),
        .result_strobe (result_strobe),
        .sorted_value  (sorted_value),
        .run_end       (run_end),
        .dropped_items (dropped_items)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stores the accepted request, or marks the set as lossy when full. A
    // closing request sorts the set (insertion sort, stable) and queues the run.
    task automatic predict_sorted_run(input elem_t value, input logic last);
        int           i;
        int           j;
        elem_t        key;
        sorted_elem_t elem;
        if (open_set.size() < MAX_ITEMS)
            open_set.push_back(value);
        else
            open_set_lost = 1'b1;
        if (last)
        begin
            for (i = 1; i < open_set.size(); i++)
            begin
                key = open_set[i];
                j = i;
                while (j > 0 && open_set[j-1] > key)
                begin
                    open_set[j] = open_set[j-1];
                    j--;
                end
                open_set[j] = key;
            end
            for (i = 0; i < open_set.size(); i++)
            begin
                elem.value   = open_set[i];
                elem.run_end = (i == open_set.size() - 1);
                elem.dropped = open_set_lost;
                sorted_run_q.push_back(elem);
            end
            open_set.delete();
            open_set_lost = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    // busy only moves on rising edges, so checking it here is race free.
    task automatic send_request(input elem_t value, input logic last);
        start      <= 1'b1;
        item_value <= value;
        is_last    <= last;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic sender_gap(input int mode);
        if (requests_sent < QUIET_FROM && mode != 0 && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    // Mix of extremes, a narrow band that forces ties, and full random words.
    function automatic elem_t pick_value();
        case ($urandom_range(0, 9))
            0:       return MOST_POS;
            1:       return MOST_NEG;
            2, 3, 4: return elem_t'($urandom_range(0, 8)) - elem_t'(4);
            default: return elem_t'($urandom);
        endcase
    endfunction

    task automatic send_random_set(input int set_size);
        int    k;
        int    mode;
        elem_t value;
        mode = $urandom_range(0, 2);
        for (k = 0; k < set_size; k++)
        begin
            sender_gap(mode);
            value = pick_value();
            send_request(value, k == set_size - 1);
            predict_sorted_run(value, k == set_size - 1);
        end
    endtask

    // Results cannot be held off, so every strobe is compared on the spot.
    always @(posedge clk)
    begin : check_results
        sorted_elem_t want;
        if (rst_n && result_strobe)
        begin
            if (sorted_run_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: sorted_value %0d run_end %0b dropped %0b",
                         $time, sorted_value, run_end, dropped_items);
            end
            else
            begin
                want = sorted_run_q.pop_front();
                if (sorted_value !== want.value)
                begin
                    error_count++;
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, want.value, sorted_value);
                end
                if (run_end !== want.run_end)
                begin
                    error_count++;
                    $display("%0t: run_end expected %0b actual %0b",
                             $time, want.run_end, run_end);
                end
                if (dropped_items !== want.dropped)
                begin
                    error_count++;
                    $display("%0t: dropped_items expected %0b actual %0b",
                             $time, want.dropped, dropped_items);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int           r;
        int           set_size;
        sorted_elem_t pinned_elem;
        rst_n         = 1'b0;
        start         = 1'b0;
        item_value    = '0;
        is_last       = 1'b0;
        open_set_lost = 1'b0;

        directed_rows = '{
            // One-element sets: the result is the value itself.
            '{MOST_NEG, 1'b1, 1'b1, MOST_NEG},
            '{MOST_POS, 1'b1, 1'b1, MOST_POS},
            '{elem_t'(0), 1'b1, 1'b1, elem_t'(0)},
            '{elem_t'(-1), 1'b1, 1'b1, elem_t'(-1)},
            // Mixed set with a tie and both extremes.
            '{elem_t'(5), 1'b0, 1'b0, elem_t'(0)},
            '{elem_t'(-1), 1'b0, 1'b0, elem_t'(0)},
            '{elem_t'(5), 1'b0, 1'b0, elem_t'(0)},
            '{MOST_POS, 1'b0, 1'b0, elem_t'(0)},
            '{MOST_NEG, 1'b0, 1'b0, elem_t'(0)},
            '{elem_t'(0), 1'b1, 1'b0, elem_t'(0)},
            // Two equal values.
            '{elem_t'(-7), 1'b0, 1'b0, elem_t'(0)},
            '{elem_t'(-7), 1'b1, 1'b0, elem_t'(0)},
            // Descending input.
            '{elem_t'(3), 1'b0, 1'b0, elem_t'(0)},
            '{elem_t'(2), 1'b0, 1'b0, elem_t'(0)},
            '{elem_t'(1), 1'b1, 1'b0, elem_t'(0)}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_request(directed_rows[r].value, directed_rows[r].last);
            if (directed_rows[r].pinned)
            begin
                pinned_elem.value   = directed_rows[r].pin_value;
                pinned_elem.run_end = 1'b1;
                pinned_elem.dropped = 1'b0;
                sorted_run_q.push_back(pinned_elem);
                open_set.delete();
                open_set_lost = 1'b0;
            end
            else
                predict_sorted_run(directed_rows[r].value, directed_rows[r].last);
        end

        // A set that exactly fills the store, then one whose closing request
        // arrives with the store full and is itself dropped.
        send_random_set(MAX_ITEMS);
        send_random_set(MAX_ITEMS + 1);

        // Mostly short sets; now and then a long one or an overflowing one.
        while (requests_sent < TOTAL_REQUESTS)
        begin
            case ($urandom_range(0, 19))
                0:       set_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
                1, 2:    set_size = $urandom_range(9, MAX_ITEMS);
                default: set_size = $urandom_range(1, 8);
            endcase
            send_random_set(set_size);
        end
        start <= 1'b0;

        while (sorted_run_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/mse_pkg.sv
sv/mse_ctrl.sv
sv/mse_datapath.sv
sv/merge_sort_engine.sv
verif/merge_sort_engine_tb.sv
